>>> rtl/hslc_pkg.sv
// shared types, constants and helpers of the hsl to rgb converter
package hslc_pkg;

    // pipeline shape
    localparam int STAGES       = 10;
    localparam int FRONT_STAGES = 5;
    localparam int BACK_STAGES  = STAGES - FRONT_STAGES;

    // field widths
    localparam int HUE_W  = 16;
    localparam int CFG_W  = 17;
    localparam int CH_W   = 8;
    localparam int RGB_W  = 3 * CH_W;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // half of the signed hue range
    localparam int HUE_HALF = 2 ** (HUE_W - 1);

    // q1.16 fractions
    localparam logic [CFG_W-1:0] Q16_ONE     = 17'd65536;
    localparam logic [CFG_W-1:0] SAT_RESET   = 17'd45875;
    localparam logic [CFG_W-1:0] LIGHT_RESET = 17'd32768;

    // chroma product a*s in 2^-32 units, offset in 2^-33 units
    localparam int AS_W       = 33;
    localparam int MM_W       = 34;
    localparam int UNIT_SHIFT = 33;

    // hue geometry
    localparam int SECTOR_DEG   = 60;
    localparam int TURN_SECTORS = 6;

    // constant division by reciprocal, one correction step after it
    localparam int DIV15       = SECTOR_DEG / 4;
    localparam int DIV3        = 3;
    localparam int RECIP_15    = 4369;
    localparam int RECIP_3     = 21845;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_15_W  = $clog2(RECIP_15 + 1);
    localparam int RECIP_3_W   = $clog2(RECIP_3 + 1);

    // second component before the final divide by 15, below 256 * 15
    localparam int V_W = 12;

    // register index taken from paddr[2]
    localparam logic REG_SATURATION = 1'b0;
    localparam logic REG_LIGHTNESS  = 1'b1;

    // channel order (r, g, b) per 60 degree sector
    typedef enum logic [2:0] {
        SEC_C_X_0 = 3'd0,
        SEC_X_C_0 = 3'd1,
        SEC_0_C_X = 3'd2,
        SEC_0_X_C = 3'd3,
        SEC_X_0_C = 3'd4,
        SEC_C_0_X = 3'd5
    } sector_t;

    // hue units in one sector
    function automatic int sector_width(input int frac_bits);
        return SECTOR_DEG << frac_bits;
    endfunction

    // width of 2 * triangle position, up to twice the sector width
    function automatic int tri_width(input int frac_bits);
        return $clog2(2 * sector_width(frac_bits) + 1);
    endfunction

    function automatic logic [CFG_W-1:0] clamp_one(input logic [CFG_W-1:0] v);
        return (v > Q16_ONE) ? Q16_ONE : v;
    endfunction

    function automatic logic [CH_W-1:0] sat_channel(input logic [CH_W:0] v);
        return v[CH_W] ? {CH_W{1'b1}} : v[CH_W-1:0];
    endfunction

endpackage

>>> rtl/hsl_to_rgb_converter_unit.sv
// top level of the hsl to rgb converter: config registers and pipeline
//
// usage
//   input channel s_valid / s_ready / s_hue carries one hue request in
//   2^-HUE_FRACTION_BITS degree units, two's complement, any value wraps
//   modulo 360 degrees. result channel m_valid / m_ready carries red, green,
//   blue and the packed 24-bit color for every request, in request order.
//   saturation (byte address 0) and lightness (byte address 4) are q1.16
//   registers on the apb port, written by the user only while no request is
//   in flight (not enforced by the block); values above 1.0 act as 1.0.
//   throughput is one request per cycle unless m_ready holds the pipeline;
//   the depth is set by the ten register stages (hue wrap and sector split,
//   chroma product, scaling by 255, divide by the sector width, sector mux).
//   reset empties the pipeline and loads saturation 0.7 and lightness 0.5.
//   when the receiver stalls each full stage holds its request, empty stages
//   behind it keep filling, and s_ready falls only once all ten are full
module hsl_to_rgb_converter_unit
    import hslc_pkg::*;
#(
    parameter int HUE_FRACTION_BITS = 4
)
(
    input  logic                     aclk,
    input  logic                     aresetn,

    // hue requests
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [HUE_W-1:0]  s_hue,

    // color results
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [CH_W-1:0]          m_red,
    output logic [CH_W-1:0]          m_green,
    output logic [CH_W-1:0]          m_blue,
    output logic [RGB_W-1:0]         m_packed_color,

    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    localparam int TW = tri_width(HUE_FRACTION_BITS);

    logic [CFG_W-1:0]  saturation_reg;
    logic [CFG_W-1:0]  lightness_reg;
    logic [STAGES-1:0] en;
    sector_t           sector;
    logic [TW-1:0]     twotri;
    logic [AS_W-1:0]   chroma_q32;
    logic [MM_W-1:0]   offset_q33;

    // apb access, zero wait states
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            saturation_reg <= SAT_RESET;
            lightness_reg  <= LIGHT_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_SATURATION: saturation_reg <= pwdata[CFG_W-1:0];
                REG_LIGHTNESS:  lightness_reg  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // read back, upper bits zero
    always_comb begin
        case (paddr[2])
            REG_SATURATION: prdata = APB_DW'(saturation_reg);
            REG_LIGHTNESS:  prdata = APB_DW'(lightness_reg);
            default:        prdata = '0;
        endcase
    end

    // valid bits and stage enables for all ten stages
    hslc_pipe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .en        (en)
    );

    // stages 0..4: hue to sector and triangle position
    hslc_hue_split #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_hue (
        .aclk   (aclk),
        .en     (en[FRONT_STAGES-1:0]),
        .hue    (s_hue),
        .sector (sector),
        .twotri (twotri)
    );

    // stages 0..4 alongside: registers captured with the request, chroma, offset
    hslc_chroma u_chroma (
        .aclk       (aclk),
        .en         (en[FRONT_STAGES-1:0]),
        .saturation (saturation_reg),
        .lightness  (lightness_reg),
        .chroma_q32 (chroma_q32),
        .offset_q33 (offset_q33)
    );

    // stages 5..9: scale, divide, mux; last stage is the output register
    hslc_chan_calc #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_chan (
        .aclk         (aclk),
        .en           (en[STAGES-1:FRONT_STAGES]),
        .sector       (sector),
        .twotri       (twotri),
        .chroma_q32   (chroma_q32),
        .offset_q33   (offset_q33),
        .red          (m_red),
        .green        (m_green),
        .blue         (m_blue),
        .packed_color (m_packed_color)
    );

endmodule

>>> rtl/hslc_pipe_ctrl.sv
// valid bits and per-stage load enables of the converter pipeline
module hslc_pipe_ctrl
    import hslc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [STAGES-1:0]  en
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;

    // a stage loads when empty or when the one after it moves
    always_comb begin
        en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb begin
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[STAGES-1];

endmodule

>>> rtl/hslc_hue_split.sv
// hue wrap, sector select and triangle position, five stages
module hslc_hue_split
    import hslc_pkg::*;
#(
    parameter int HUE_FRACTION_BITS = 4
)
(
    input  logic                                    aclk,
    input  logic [FRONT_STAGES-1:0]                 en,
    input  logic signed [HUE_W-1:0]                 hue,
    output sector_t                                 sector,
    output logic [tri_width(HUE_FRACTION_BITS)-1:0] twotri
);

    localparam int W_VAL  = sector_width(HUE_FRACTION_BITS);
    localparam int FULL   = TURN_SECTORS * W_VAL;
    localparam int OFFS   = FULL * ((HUE_HALF + FULL - 1) / FULL);
    localparam int X_MAX  = HUE_HALF - 1 + OFFS;
    localparam int XW     = $clog2(X_MAX + 1);
    localparam int YSH    = HUE_FRACTION_BITS + 2;
    localparam int Y_MAX  = X_MAX >> YSH;
    localparam int YW     = $clog2(Y_MAX + 1);
    localparam int Q_MAX  = Y_MAX / DIV15;
    localparam int QW     = $clog2(Q_MAX + 1);
    localparam int QH_MAX = Q_MAX >> 1;
    localparam int QHW    = $clog2(QH_MAX + 1);
    localparam int PW     = $clog2(W_VAL);
    localparam int TW     = tri_width(HUE_FRACTION_BITS);
    localparam int P1W    = YW + RECIP_15_W;
    localparam int P3W    = QHW + RECIP_3_W;

    logic [XW-1:0]  x0_reg, x1_reg, x2_reg;
    logic [XW-1:0]  x0_next;
    logic [QW-1:0]  qest1_reg, qest1_next;
    logic [QW-1:0]  q2_reg, q2_next;
    logic [PW-1:0]  p3_reg, p3_next;
    logic [QHW-1:0] qh3_reg, qh3_next;
    logic [QHW-1:0] e3_reg, e3_next;
    logic           q0_3_reg;
    sector_t        sector4_reg, sector4_next;
    logic [TW-1:0]  twotri4_reg, twotri4_next;

    logic [YW-1:0]  y1, y2, rem2;
    logic [P1W-1:0] prod1;
    logic [XW-1:0]  qw3;
    logic [P3W-1:0] prod3;
    logic [QHW-1:0] r3;
    logic [1:0]     rem3;
    logic [PW:0]    two_p, fold_dist, tri_pos;

    // shift the hue by whole turns so it is never negative
    assign x0_next = XW'(int'(hue) + OFFS);

    // sixtieth count estimate, x / W = (x >> (F+2)) / 15
    assign y1         = YW'(x0_reg >> YSH);
    assign prod1      = P1W'(y1) * P1W'(RECIP_15);
    assign qest1_next = QW'(prod1 >> RECIP_SHIFT);

    always_comb begin
        y2   = YW'(x1_reg >> YSH);
        rem2 = y2 - YW'(qest1_reg) * YW'(DIV15);
        if (rem2 >= YW'(DIV15)) begin
            q2_next = qest1_reg + QW'(1);
        end else begin
            q2_next = qest1_reg;
        end
    end

    // position in sector and sector count mod 3 estimate
    assign qw3      = XW'(q2_reg) * XW'(W_VAL);
    assign p3_next  = PW'(x2_reg - qw3);
    assign qh3_next = QHW'(q2_reg >> 1);
    assign prod3    = P3W'(qh3_next) * P3W'(RECIP_3);
    assign e3_next  = QHW'(prod3 >> RECIP_SHIFT);

    always_comb begin
        r3 = qh3_reg - e3_reg * QHW'(DIV3);
        if (r3 >= QHW'(DIV3)) begin
            rem3 = 2'(r3 - QHW'(DIV3));
        end else begin
            rem3 = 2'(r3);
        end
        sector4_next = sector_t'({rem3, q0_3_reg});

        // triangle W - |2p - W|, kept doubled
        two_p = {p3_reg, 1'b0};
        if (two_p >= (PW+1)'(W_VAL)) begin
            fold_dist = two_p - (PW+1)'(W_VAL);
        end else begin
            fold_dist = (PW+1)'(W_VAL) - two_p;
        end
        tri_pos      = (PW+1)'(W_VAL) - fold_dist;
        twotri4_next = TW'({tri_pos, 1'b0});
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x0_reg <= x0_next;
        end
        if (en[1]) begin
            x1_reg    <= x0_reg;
            qest1_reg <= qest1_next;
        end
        if (en[2]) begin
            x2_reg <= x1_reg;
            q2_reg <= q2_next;
        end
        if (en[3]) begin
            p3_reg   <= p3_next;
            qh3_reg  <= qh3_next;
            e3_reg   <= e3_next;
            q0_3_reg <= q2_reg[0];
        end
        if (en[4]) begin
            sector4_reg <= sector4_next;
            twotri4_reg <= twotri4_next;
        end
    end

    assign sector = sector4_reg;
    assign twotri = twotri4_reg;

endmodule

>>> rtl/hslc_chroma.sv
// chroma and offset from saturation and lightness, five stages
module hslc_chroma
    import hslc_pkg::*;
(
    input  logic                     aclk,
    input  logic [FRONT_STAGES-1:0]  en,
    input  logic [CFG_W-1:0]         saturation,
    input  logic [CFG_W-1:0]         lightness,
    output logic [AS_W-1:0]          chroma_q32,
    output logic [MM_W-1:0]          offset_q33
);

    logic [CFG_W-1:0] s0_reg, s1_reg;
    logic [CFG_W-1:0] l0_reg, l1_reg, l2_reg;
    logic [CFG_W-1:0] a1_reg, a1_next;
    logic [AS_W-1:0]  as2_reg, as3_reg, as4_reg;
    logic [AS_W-1:0]  as2_next;
    logic [MM_W-1:0]  mm3_reg, mm4_reg;
    logic [MM_W-1:0]  mm3_next;
    logic [CFG_W:0]   dbl;
    logic [2*CFG_W-1:0] prod2;

    // a = 1 - |2l - 1|
    always_comb begin
        dbl = {l0_reg, 1'b0};
        if (dbl >= (CFG_W+1)'(Q16_ONE)) begin
            a1_next = CFG_W'({Q16_ONE - l0_reg, 1'b0});
        end else begin
            a1_next = CFG_W'(dbl);
        end
    end

    assign prod2    = (2*CFG_W)'(a1_reg) * (2*CFG_W)'(s1_reg);
    assign as2_next = AS_W'(prod2);

    // offset l - c/2, never negative
    assign mm3_next = {l2_reg, {CFG_W{1'b0}}} - MM_W'(as2_reg);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s0_reg <= clamp_one(saturation);
            l0_reg <= clamp_one(lightness);
        end
        if (en[1]) begin
            s1_reg <= s0_reg;
            l1_reg <= l0_reg;
            a1_reg <= a1_next;
        end
        if (en[2]) begin
            l2_reg  <= l1_reg;
            as2_reg <= as2_next;
        end
        if (en[3]) begin
            as3_reg <= as2_reg;
            mm3_reg <= mm3_next;
        end
        if (en[4]) begin
            as4_reg <= as3_reg;
            mm4_reg <= mm3_reg;
        end
    end

    assign chroma_q32 = as4_reg;
    assign offset_q33 = mm4_reg;

endmodule

>>> rtl/hslc_chan_calc.sv
// channel scaling by 255, divide by sector width, sector mux, five stages
module hslc_chan_calc
    import hslc_pkg::*;
#(
    parameter int HUE_FRACTION_BITS = 4
)
(
    input  logic                                    aclk,
    input  logic [BACK_STAGES-1:0]                  en,
    input  sector_t                                 sector,
    input  logic [tri_width(HUE_FRACTION_BITS)-1:0] twotri,
    input  logic [AS_W-1:0]                         chroma_q32,
    input  logic [MM_W-1:0]                         offset_q33,
    output logic [CH_W-1:0]                         red,
    output logic [CH_W-1:0]                         green,
    output logic [CH_W-1:0]                         blue,
    output logic [RGB_W-1:0]                        packed_color
);

    localparam int W_VAL = sector_width(HUE_FRACTION_BITS);
    localparam int TW    = tri_width(HUE_FRACTION_BITS);
    localparam int PW    = $clog2(W_VAL);
    localparam int PRW   = AS_W + TW;
    localparam int QQW   = MM_W + PW;
    localparam int SW    = ((PRW > QQW) ? PRW : QQW) + 1;
    localparam int C255W = MM_W + CH_W;
    localparam int VSH   = UNIT_SHIFT + 2 + HUE_FRACTION_BITS;
    localparam int P8W   = V_W + RECIP_15_W;

    logic [PRW-1:0]  p5_reg, p5_next;
    logic [QQW-1:0]  q5_reg, q5_next;
    logic [MM_W-1:0] cs5_reg, cs5_next;
    logic [MM_W-1:0] mm5_reg;
    sector_t         sec5_reg, sec6_reg, sec7_reg, sec8_reg;
    logic [SW-1:0]   sum6_reg, sum6_next;
    logic [CH_W:0]   cval6_reg, cval7_reg, cval8_reg, cval6_next;
    logic [CH_W:0]   zval6_reg, zval7_reg, zval8_reg, zval6_next;
    logic [V_W-1:0]  v7_reg, v8_reg, v7_next;
    logic [CH_W:0]   e8_reg, e8_next;
    logic [CH_W-1:0] red_reg, green_reg, blue_reg;
    logic [CH_W-1:0] red_next, green_next, blue_next;
    logic [RGB_W-1:0] packed_reg;

    logic [C255W-1:0] c255, z255;
    logic [SW+CH_W-1:0] s255;
    logic [P8W-1:0]   prod8;
    logic [V_W-1:0]   rem9;
    logic [CH_W:0]    xval;
    logic [CH_W-1:0]  c_ch, x_ch, z_ch;

    // second component numerator: as * 2tri + W * offset
    assign p5_next  = PRW'(chroma_q32) * PRW'(twotri);
    assign q5_next  = QQW'(offset_q33) * QQW'(W_VAL);
    // full chroma channel is offset + c
    assign cs5_next = offset_q33 + {chroma_q32, 1'b0};

    // times 255 as shift and subtract
    assign sum6_next  = SW'(p5_reg) + SW'(q5_reg);
    assign c255       = {cs5_reg, {CH_W{1'b0}}} - C255W'(cs5_reg);
    assign z255       = {mm5_reg, {CH_W{1'b0}}} - C255W'(mm5_reg);
    assign cval6_next = (CH_W+1)'(c255 >> UNIT_SHIFT);
    assign zval6_next = (CH_W+1)'(z255 >> UNIT_SHIFT);

    assign s255    = {sum6_reg, {CH_W{1'b0}}} - (SW+CH_W)'(sum6_reg);
    assign v7_next = V_W'(s255 >> VSH);

    // remaining divide by 15
    assign prod8   = P8W'(v7_reg) * P8W'(RECIP_15);
    assign e8_next = (CH_W+1)'(prod8 >> RECIP_SHIFT);

    always_comb begin
        rem9 = v8_reg - V_W'(e8_reg) * V_W'(DIV15);
        if (rem9 >= V_W'(DIV15)) begin
            xval = e8_reg + (CH_W+1)'(1);
        end else begin
            xval = e8_reg;
        end
        c_ch = sat_channel(cval8_reg);
        x_ch = sat_channel(xval);
        z_ch = sat_channel(zval8_reg);
        case (sec8_reg)
            SEC_C_X_0: begin
                red_next = c_ch; green_next = x_ch; blue_next = z_ch;
            end
            SEC_X_C_0: begin
                red_next = x_ch; green_next = c_ch; blue_next = z_ch;
            end
            SEC_0_C_X: begin
                red_next = z_ch; green_next = c_ch; blue_next = x_ch;
            end
            SEC_0_X_C: begin
                red_next = z_ch; green_next = x_ch; blue_next = c_ch;
            end
            SEC_X_0_C: begin
                red_next = x_ch; green_next = z_ch; blue_next = c_ch;
            end
            default: begin
                red_next = c_ch; green_next = z_ch; blue_next = x_ch;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            p5_reg   <= p5_next;
            q5_reg   <= q5_next;
            cs5_reg  <= cs5_next;
            mm5_reg  <= offset_q33;
            sec5_reg <= sector;
        end
        if (en[1]) begin
            sum6_reg  <= sum6_next;
            cval6_reg <= cval6_next;
            zval6_reg <= zval6_next;
            sec6_reg  <= sec5_reg;
        end
        if (en[2]) begin
            v7_reg    <= v7_next;
            cval7_reg <= cval6_reg;
            zval7_reg <= zval6_reg;
            sec7_reg  <= sec6_reg;
        end
        if (en[3]) begin
            v8_reg    <= v7_reg;
            e8_reg    <= e8_next;
            cval8_reg <= cval7_reg;
            zval8_reg <= zval7_reg;
            sec8_reg  <= sec7_reg;
        end
        if (en[4]) begin
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            packed_reg <= {red_next, green_next, blue_next};
        end
    end

    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign packed_color = packed_reg;

endmodule

>>> dv/hsl_to_rgb_converter_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the hsl to rgb converter unit
module hsl_to_rgb_converter_unit_tb
    import hslc_pkg::*;
();

    // hue geometry at the fraction width the block is built with
    localparam int HUE_FRAC   = 4;
    localparam int HUE_TURN   = 360 << HUE_FRAC;
    localparam int HUE_SECTOR = 60 << HUE_FRAC;

    // run shape
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 14;
    localparam int PHASE_REQUESTS = 92;
    localparam int MAX_REPORTS    = 10;
    localparam int LONG_HOLD      = 150;

    // one expected color, with the hue that caused it for the report
    typedef struct {
        logic signed [HUE_W-1:0] hue;
        logic [CH_W-1:0]         red;
        logic [CH_W-1:0]         green;
        logic [CH_W-1:0]         blue;
        logic [RGB_W-1:0]        packed_color;
    } color_t;

    logic                    aclk    = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [HUE_W-1:0] s_hue   = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [CH_W-1:0]         m_red;
    logic [CH_W-1:0]         m_green;
    logic [CH_W-1:0]         m_blue;
    logic [RGB_W-1:0]        m_packed_color;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [APB_AW-1:0]       paddr   = '0;
    logic [APB_DW-1:0]       pwdata  = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    // our own copy of the two registers, as written over the bus
    logic [CFG_W-1:0] sat_cfg   = SAT_RESET;
    logic [CFG_W-1:0] light_cfg = LIGHT_RESET;

    // colors predicted for accepted hues, oldest first
    color_t expected_colors[$];

    int errors         = 0;
    int quiet_cycles   = 0;
    int rx_hold_cycles = 0;
    bit tx_idle        = 1'b1;
    bit rx_idle        = 1'b1;

    always #1 aclk = ~aclk;

    hsl_to_rgb_converter_unit #(
        .HUE_FRACTION_BITS(HUE_FRAC)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_hue          (s_hue),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_packed_color (m_packed_color),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    task automatic log_mismatch(input string what);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("mismatch: %s", what);
        end
    endtask

    // (component + offset) * 255, truncated, limited to full scale
    function automatic logic [CH_W-1:0] scale_to_channel(input logic [63:0] num,
                                                         input logic [63:0] den);
        logic [63:0] v;
        v = (num * 64'd255) / den;
        return (v > 64'd255) ? {CH_W{1'b1}} : v[CH_W-1:0];
    endfunction

    // exact hsl to rgb: all terms kept over the common denominator 2^33 * sector width
    function automatic color_t predict_color(input logic signed [HUE_W-1:0] hue,
                                             input logic [CFG_W-1:0] sat_reg,
                                             input logic [CFG_W-1:0] light_reg);
        int          wrapped;
        logic [63:0] s, l, a, chroma32, pos, tri_h, den, c_num, x_num, m_num;
        logic [63:0] r_num, g_num, b_num;
        color_t      c;
        wrapped = int'(hue) % HUE_TURN;
        if (wrapped < 0) begin
            wrapped += HUE_TURN;
        end
        pos = 64'(wrapped % HUE_SECTOR);

        // values above 1.0 act as 1.0
        s = (sat_reg > Q16_ONE) ? 64'(Q16_ONE) : 64'(sat_reg);
        l = (light_reg > Q16_ONE) ? 64'(Q16_ONE) : 64'(light_reg);

        // 1 - |2l - 1| in q1.16, chroma in 2^-32 units
        a = (2 * l >= 64'd65536) ? 64'd131072 - 2 * l : 2 * l;
        chroma32 = a * s;

        // triangle over the sector: 2p rising, then 2w - 2p falling
        tri_h = (2 * pos >= HUE_SECTOR) ? 64'(2 * HUE_SECTOR) - 2 * pos : 2 * pos;

        den   = (64'd1 << 33) * HUE_SECTOR;
        c_num = chroma32 * 2 * HUE_SECTOR;
        x_num = chroma32 * 2 * tri_h;
        m_num = l * (64'd1 << 17) * HUE_SECTOR - chroma32 * HUE_SECTOR;

        case (sector_t'(wrapped / HUE_SECTOR))
            SEC_C_X_0: begin r_num = c_num; g_num = x_num; b_num = 0;     end
            SEC_X_C_0: begin r_num = x_num; g_num = c_num; b_num = 0;     end
            SEC_0_C_X: begin r_num = 0;     g_num = c_num; b_num = x_num; end
            SEC_0_X_C: begin r_num = 0;     g_num = x_num; b_num = c_num; end
            SEC_X_0_C: begin r_num = x_num; g_num = 0;     b_num = c_num; end
            default:   begin r_num = c_num; g_num = 0;     b_num = x_num; end
        endcase

        c.hue          = hue;
        c.red          = scale_to_channel(r_num + m_num, den);
        c.green        = scale_to_channel(g_num + m_num, den);
        c.blue         = scale_to_channel(b_num + m_num, den);
        c.packed_color = {c.red, c.green, c.blue};
        return c;
    endfunction

    // every accepted hue request gets its color predicted with the current registers
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_colors.push_back(predict_color(s_hue, sat_cfg, light_cfg));
        end
    end

    // compare each accepted color against the oldest prediction
    always @(posedge aclk) begin : check_results
        color_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_colors.size() == 0) begin
                log_mismatch($sformatf("color %06h with no request outstanding",
                                       m_packed_color));
            end else begin
                want = expected_colors.pop_front();
                if (m_red !== want.red || m_green !== want.green ||
                    m_blue !== want.blue || m_packed_color !== want.packed_color) begin
                    log_mismatch($sformatf(
                        "hue %0d: expected rgb %0d %0d %0d packed %06h, got %0d %0d %0d %06h",
                        want.hue, want.red, want.green, want.blue, want.packed_color,
                        m_red, m_green, m_blue, m_packed_color));
                end
            end
        end
    end

    // ends a hung run: too many cycles in a row with no handshake anywhere
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[hsl_to_rgb_converter_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stall before each color while rx_idle is set, plus the long hold-off on request
    initial begin : result_sink
        int stall;
        wait (aresetn);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            stall = rx_idle ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            // a hold-off request breaks the wait so it starts right away
            while (!m_valid && rx_hold_cycles == 0) @(posedge aclk);
        end
    end

    // offer one hue request after a random gap; returns at the accepting edge.
    // valid is only lowered when a gap follows, so it never toggles within a step
    task automatic send_hue(input logic signed [HUE_W-1:0] hue);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_hue   <= hue;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop offering and wait until every predicted color has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_colors.size() != 0) @(posedge aclk);
    endtask

    // apb write: setup phase, access phase, then the bus goes idle
    task automatic write_reg(input logic reg_sel, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({reg_sel, 2'b00});
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        // only the low 17 bits are kept
        if (reg_sel == REG_SATURATION) begin
            sat_cfg = data[CFG_W-1:0];
        end else begin
            light_cfg = data[CFG_W-1:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // apb read, compared against our copy of the register
    task automatic check_reg(input logic reg_sel, input logic [CFG_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'({reg_sel, 2'b00});
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== APB_DW'(want)) begin
            log_mismatch($sformatf("register %0d read %0h, expected %0h",
                                   reg_sel, prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // registers change only with the pipeline empty
    task automatic set_config(input logic [APB_DW-1:0] sat_word,
                              input logic [APB_DW-1:0] light_word);
        wait_drained();
        write_reg(REG_SATURATION, sat_word);
        write_reg(REG_LIGHTNESS, light_word);
        check_reg(REG_SATURATION, sat_cfg);
        check_reg(REG_LIGHTNESS, light_cfg);
    endtask

    // mostly any 16-bit pattern, sometimes right at a sector edge a few turns away
    function automatic logic signed [HUE_W-1:0] random_hue();
        int edge_pos;
        int turns;
        if ($urandom_range(0, 3) == 0) begin
            edge_pos = int'($urandom_range(0, 6)) * HUE_SECTOR + int'($urandom_range(0, 4)) - 2;
            turns    = int'($urandom_range(0, 8)) - 4;
            return HUE_W'(edge_pos + turns * HUE_TURN);
        end
        return HUE_W'($urandom_range(0, 65535));
    endfunction

    // register words: in range, around 1.0, over 1.0, and with stray upper bits
    function automatic logic [APB_DW-1:0] random_reg_word();
        case ($urandom_range(0, 4))
            0:       return $urandom();
            1:       return APB_DW'($urandom_range(0, 131071));
            2:       return APB_DW'(Q16_ONE) + APB_DW'($urandom_range(0, 4)) - 2;
            default: return APB_DW'($urandom_range(0, 65536));
        endcase
    endfunction

    // reset values read back, then a color at the default saturation and lightness
    task automatic test_reset_values();
        check_reg(REG_SATURATION, SAT_RESET);
        check_reg(REG_LIGHTNESS, LIGHT_RESET);
        send_hue(16'sd0);
    endtask

    // hue extremes, sector edges and both wrap directions
    task automatic test_hue_extremes();
        send_hue(16'sd1);
        send_hue(-16'sd1);
        send_hue(16'sd32767);
        send_hue(-16'sd32768);
        // peak of the second component in sector 0
        send_hue(HUE_W'(HUE_SECTOR / 2));
        // last unit of a sector and the first of each following one
        send_hue(HUE_W'(HUE_SECTOR - 1));
        send_hue(HUE_W'(HUE_SECTOR));
        send_hue(HUE_W'(2 * HUE_SECTOR));
        send_hue(HUE_W'(3 * HUE_SECTOR));
        send_hue(HUE_W'(4 * HUE_SECTOR));
        send_hue(HUE_W'(5 * HUE_SECTOR));
        send_hue(HUE_W'(5 * HUE_SECTOR + HUE_SECTOR / 2));
        send_hue(HUE_W'(HUE_TURN - 1));
        // exactly one turn either way lands on zero
        send_hue(HUE_W'(HUE_TURN));
        send_hue(HUE_W'(-HUE_TURN));
        send_hue(HUE_W'(-HUE_SECTOR));
        send_hue(HUE_W'(-HUE_SECTOR - 1));
    endtask

    // registers above 1.0, and full chroma where a channel lands exactly on 255
    task automatic test_register_clamp();
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_hue(16'sd0);
        send_hue(16'sd2000);
        set_config(APB_DW'(Q16_ONE), APB_DW'(LIGHT_RESET));
        send_hue(16'sd0);
        send_hue(HUE_W'(2 * HUE_SECTOR));
        send_hue(HUE_W'(4 * HUE_SECTOR));
    endtask

    // receiver holds off long enough for the pipe to fill and stall the input,
    // then the sender stops until every color is back before going on
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold_cycles = LONG_HOLD;
        repeat (40) send_hue(random_hue());
        wait_drained();
        repeat (20) send_hue(random_hue());
        wait_drained();
    endtask

    // random hues across several register settings, extremes first
    task automatic test_random_sweep();
        logic [APB_DW-1:0] sat_word;
        logic [APB_DW-1:0] light_word;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       begin sat_word = 0;        light_word = 0;        end
                1:       begin sat_word = 65536;    light_word = 65536;    end
                2:       begin sat_word = 131071;   light_word = 0;        end
                3:       begin sat_word = 65536;    light_word = 32768;    end
                4:       begin sat_word = 0;        light_word = 65536;    end
                5:       begin sat_word = 65536;    light_word = 1;        end
                6:       begin sat_word = 1;        light_word = 65535;    end
                default: begin
                    sat_word   = random_reg_word();
                    light_word = random_reg_word();
                end
            endcase
            set_config(sat_word, light_word);
            // cycle through both sides idling, one side only, and neither
            tx_idle = (phase % 4) < 2;
            rx_idle = (phase % 2) == 0;
            repeat (PHASE_REQUESTS) send_hue(random_hue());
        end
    endtask

    initial begin : main_sequence
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_hue_extremes();
        test_register_clamp();
        test_backpressure();
        test_random_sweep();

        // let any stray color show up before the verdict
        wait_drained();
        repeat (STAGES + 4) @(posedge aclk);
        if (expected_colors.size() != 0) begin
            log_mismatch($sformatf("%0d colors never arrived", expected_colors.size()));
        end

        if (errors == 0) begin
            $display("[hsl_to_rgb_converter_unit] OK");
        end else begin
            $display("[hsl_to_rgb_converter_unit] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/hslc_pkg.sv
rtl/hslc_pipe_ctrl.sv
rtl/hslc_hue_split.sv
rtl/hslc_chroma.sv
rtl/hslc_chan_calc.sv
rtl/hsl_to_rgb_converter_unit.sv
dv/hsl_to_rgb_converter_unit_tb.sv
